// ----- hdl/greedy_wildcard_matcher_unit_defines.svh -----
// Assertion macros for the greedy wildcard matcher.
// Included by files that carry concurrent checks; expects clk and rst in scope.
`ifndef GREEDY_WILDCARD_MATCHER_UNIT_DEFINES_SVH
`define GREEDY_WILDCARD_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GWM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gwm_pkg.sv -----
// Shared constants, types and the case-fold function of the wildcard matcher.
// No dependencies.
package gwm_pkg;

  localparam int MASK_DEPTH = 256;
  localparam int PTR_W      = $clog2(MASK_DEPTH + 1);
  localparam int ADDR_W     = $clog2(MASK_DEPTH);
  localparam int SYM_W      = 8;

  localparam logic [SYM_W-1:0] SYM_END  = 8'h00;
  localparam logic [SYM_W-1:0] SYM_ANY  = 8'h3F;  // '?'
  localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;  // '*'
  localparam logic [SYM_W-1:0] LOWER_A  = 8'h61;
  localparam logic [SYM_W-1:0] LOWER_Z  = 8'h7A;
  localparam logic [SYM_W-1:0] CASE_OFS = 8'h20;

  localparam logic FUNC_MASK = 1'b0;
  localparam logic FUNC_NAME = 1'b1;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SKIP   = 2'd1,
    MODE_FAIL   = 2'd2
  } mode_t;

  // Mask store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [SYM_W-1:0]  data;
  } gwm_wr_t;

  // One judged filename
  typedef struct packed {
    logic valid;
    logic matched;
    logic too_long;
  } gwm_result_t;

  // Pointer state seen by the top-level checks
  typedef struct packed {
    logic [PTR_W-1:0] pos;
    logic [PTR_W-1:0] load_count;
  } gwm_status_t;

  // Fold a-z to A-Z
  function automatic logic [SYM_W-1:0] fold(input logic [SYM_W-1:0] s);
    logic [SYM_W-1:0] r;
    r = s;
    if (s >= LOWER_A && s <= LOWER_Z) begin
      r = s - CASE_OFS;
    end
    return r;
  endfunction

endpackage

// ----- hdl/gwm_ram.sv -----
// Generic simple RAM: one write port, two registered read ports, write-first.
// No dependencies.
module gwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, new data forwarded on an address collision
  always_ff @(posedge clk) begin
    rdata0 <= (we && waddr == raddr0) ? wdata : mem[raddr0];
    rdata1 <= (we && waddr == raddr1) ? wdata : mem[raddr1];
  end

endmodule

// ----- hdl/gwm_core.sv -----
// Matcher state and per-byte decision: mask loading, compare, '*' skipping.
// Depends on gwm_pkg; reads the mask store through two registered read ports.
module gwm_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      commit,
  input  logic                      func,
  input  logic [gwm_pkg::SYM_W-1:0] symbol,
  input  logic [gwm_pkg::SYM_W-1:0] rd0,
  input  logic [gwm_pkg::SYM_W-1:0] rd1,
  output logic [gwm_pkg::ADDR_W-1:0] raddr0,
  output logic [gwm_pkg::ADDR_W-1:0] raddr1,
  output gwm_pkg::gwm_wr_t           wr,
  output gwm_pkg::gwm_result_t       result,
  output gwm_pkg::gwm_status_t       status
);
  import gwm_pkg::*;

  logic [PTR_W-1:0] load_count, load_count_next;
  logic [PTR_W-1:0] pos, pos_next;
  mode_t            mode, mode_next;
  logic             overflow, overflow_next;
  logic             closed, closed_next;

  logic [SYM_W-1:0] f;
  logic [SYM_W-1:0] m0, m1;
  logic [PTR_W:0]   pos_plus1;
  logic [PTR_W-1:0] lc_eff;
  logic             term;

  // Folded byte and mask entries at pos and pos+1; beyond the mask reads as end
  assign f         = fold(symbol);
  assign term      = (f == SYM_END);
  assign pos_plus1 = {1'b0, pos} + (PTR_W+1)'(1);
  assign m0        = (pos < load_count) ? rd0 : SYM_END;
  assign m1        = (pos_plus1 < {1'b0, load_count}) ? rd1 : SYM_END;
  assign lc_eff    = closed ? '0 : load_count;

  // Next state
  always_comb begin
    load_count_next = load_count;
    pos_next        = pos;
    mode_next       = mode;
    overflow_next   = overflow;
    closed_next     = closed;
    wr.en           = 1'b0;
    wr.addr         = lc_eff[ADDR_W-1:0];
    wr.data         = f;
    if (commit) begin
      if (func == FUNC_MASK) begin
        load_count_next = lc_eff;
        overflow_next   = closed ? 1'b0 : overflow;
        closed_next     = term;
        pos_next        = '0;
        mode_next       = MODE_NORMAL;
        if (!term) begin
          if (lc_eff < PTR_W'(MASK_DEPTH)) begin
            wr.en           = 1'b1;
            load_count_next = lc_eff + PTR_W'(1);
          end else begin
            overflow_next = 1'b1;
          end
        end
      end else begin
        closed_next = 1'b1;
        if (term) begin
          pos_next  = '0;
          mode_next = MODE_NORMAL;
        end else begin
          unique case (mode)
            MODE_FAIL: begin
              mode_next = MODE_FAIL;
            end
            MODE_SKIP: begin
              if (f == m0) begin
                pos_next  = pos + PTR_W'(1);
                mode_next = MODE_NORMAL;
              end
            end
            MODE_NORMAL: begin
              priority if (m0 == SYM_ANY || m0 == f) begin
                pos_next = pos + PTR_W'(1);
              end else if (m0 == SYM_STAR) begin
                if (f == m1) begin
                  pos_next = pos + PTR_W'(2);
                end else begin
                  pos_next  = pos + PTR_W'(1);
                  mode_next = MODE_SKIP;
                end
              end else begin
                mode_next = MODE_FAIL;
              end
            end
            default: begin
              mode_next = MODE_FAIL;
            end
          endcase
        end
      end
    end
  end

  // Result on a filename terminator
  always_comb begin
    result.valid    = commit && func == FUNC_NAME && term;
    result.too_long = overflow;
    unique case (mode)
      MODE_FAIL:   result.matched = 1'b0;
      MODE_SKIP:   result.matched = (m0 == SYM_END);
      MODE_NORMAL: result.matched = (m0 == SYM_END) || (m0 == SYM_STAR && m1 == SYM_END);
      default:     result.matched = 1'b0;
    endcase
  end

  // Read addresses follow the next pointer so data is ready for the next byte
  assign raddr0 = pos_next[ADDR_W-1:0];
  assign raddr1 = ADDR_W'(pos_next + PTR_W'(1));

  assign status.pos        = pos;
  assign status.load_count = load_count;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      pos        <= '0;
      mode       <= MODE_NORMAL;
      overflow   <= 1'b0;
      closed     <= 1'b0;
    end else begin
      load_count <= load_count_next;
      pos        <= pos_next;
      mode       <= mode_next;
      overflow   <= overflow_next;
      closed     <= closed_next;
    end
  end

endmodule

// ----- hdl/greedy_wildcard_matcher_unit.sv -----
// Greedy wildcard matcher: loads a case-folded mask ('?' one byte, '*' a greedy
// skip with no backtracking) and judges streamed filenames against it. Takes one
// byte per clock, mask or filename, back to back, unless a held result stalls it;
// a terminator passes the input register, its result the output register. The rate is
// set by the mask pointer loop: the store is read at the next pointer value
// through a registered read, so each byte's mask bytes are ready in the next cycle.
// The mask store has no reset and no clearing pass; only loaded entries are used.
// Depends on gwm_pkg, gwm_core, gwm_ram and greedy_wildcard_matcher_unit_defines.svh.
`include "greedy_wildcard_matcher_unit_defines.svh"

module greedy_wildcard_matcher_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic       s_tuser,   // [0] func
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] matched, [1] mask_too_long, [7:2] zero
);
  import gwm_pkg::*;

  logic              in_valid;
  logic              in_func;
  logic [SYM_W-1:0]  in_sym;
  logic              commit;
  logic              out_matched;
  logic              out_too_long;

  logic [ADDR_W-1:0] raddr0, raddr1;
  logic [SYM_W-1:0]  rd0, rd1;
  gwm_wr_t           wr;
  gwm_result_t       result;
  gwm_status_t       status;

  // Byte in the input register is processed when the output slot can take a result
  assign commit   = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || commit;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func <= s_tuser;
      in_sym  <= s_tdata;
    end
  end

  gwm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .commit (commit),
    .func   (in_func),
    .symbol (in_sym),
    .rd0    (rd0),
    .rd1    (rd1),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .wr     (wr),
    .result (result),
    .status (status)
  );

  gwm_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MASK_DEPTH)
  ) u_mask_ram (
    .clk    (clk),
    .we     (wr.en),
    .waddr  (wr.addr),
    .wdata  (wr.data),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      out_matched  <= result.matched;
      out_too_long <= result.too_long;
    end
  end

  assign m_tdata = {6'b0, out_too_long, out_matched};

  // Checks
  `GWM_ASSERT_NEXT(a_term_gives_result, commit && in_func == FUNC_NAME && fold(in_sym) == SYM_END, m_tvalid, "filename terminator produced no result")
  `GWM_ASSERT_IMPL(a_result_from_commit, $rose(m_tvalid), $past(commit) && $past(in_func) == FUNC_NAME, "result without a committed filename byte")
  `GWM_ASSERT_IMPL(a_pos_in_mask, 1'b1, status.pos <= status.load_count, "mask pointer ran past the loaded mask")

endmodule

// ----- test/greedy_wildcard_matcher_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for greedy_wildcard_matcher_unit: directed rows, then mask/name runs.
// Depends on gwm_pkg and the matcher RTL; holds its own model of the matcher.
module greedy_wildcard_matcher_unit_test;
  import gwm_pkg::*;

  localparam int DIRECTED_ROWS = 28;
  localparam int RANDOM_ITEMS  = 750;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int QUIET_LIMIT   = 2000;

  // One judged name: matched, then mask_too_long
  typedef struct packed {
    logic matched;
    logic too_long;
  } verdict_t;

  // One input transaction, with an optional hand-written verdict
  typedef struct packed {
    logic       typed;
    verdict_t   typed_v;
    logic       func;
    logic [7:0] sym;
  } item_t;

  // Row prefixes: {typed, matched, too_long}
  localparam logic [2:0] FREE = 3'b000;
  localparam logic [2:0] HIT  = 3'b110;
  localparam logic [2:0] MISS = 3'b100;

  localparam item_t DIRECTED [DIRECTED_ROWS] = '{
    {HIT,  FUNC_NAME, SYM_END},  // empty name against the empty mask after reset
    {FREE, FUNC_MASK, 8'h61},    // mask "a*C?" (lower case folds)
    {FREE, FUNC_MASK, SYM_STAR},
    {FREE, FUNC_MASK, 8'h43},
    {FREE, FUNC_MASK, SYM_ANY},
    {FREE, FUNC_MASK, SYM_END},
    {FREE, FUNC_NAME, 8'h41},    // "AxcFF": star skips x, '?' takes 0xFF
    {FREE, FUNC_NAME, 8'h78},
    {FREE, FUNC_NAME, 8'h63},
    {FREE, FUNC_NAME, 8'hFF},
    {FREE, FUNC_NAME, SYM_END},
    {FREE, FUNC_NAME, 8'h61},    // "ac": '?' left over at the terminator
    {FREE, FUNC_NAME, 8'h63},
    {FREE, FUNC_NAME, SYM_END},
    {FREE, FUNC_NAME, 8'h62},    // "bZ": fails on the first byte, rest ignored
    {FREE, FUNC_NAME, 8'h5A},
    {MISS, FUNC_NAME, SYM_END},
    {FREE, FUNC_NAME, SYM_END},  // empty name against a nonempty mask
    {FREE, FUNC_NAME, 8'h61},    // name cut short by a new mask "*"
    {FREE, FUNC_MASK, SYM_STAR},
    {FREE, FUNC_MASK, SYM_END},
    {FREE, FUNC_NAME, 8'hFF},    // skipping, then terminator right after the star
    {FREE, FUNC_NAME, SYM_END},
    {FREE, FUNC_MASK, SYM_STAR}, // mask "*q"
    {FREE, FUNC_MASK, 8'h71},
    {FREE, FUNC_MASK, SYM_END},
    {FREE, FUNC_NAME, 8'h78},    // terminator while still hunting for Q
    {MISS, FUNC_NAME, SYM_END}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;      // [7:0] symbol
  logic       s_tuser = 1'b0;    // [0] func
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [0] matched, [1] mask_too_long, [7:2] zero

  item_t    byte_stream [$];
  item_t    offered = '0;
  verdict_t expected_verdicts [$];
  int       error_count = 0;
  int       quiet_cycles = 0;
  bit       hold_req = 1'b0;

  // Model state
  logic [7:0]  mask_copy [MASK_DEPTH];
  int unsigned held_len = 0;
  int unsigned cur_pos = 0;
  mode_t       cur_mode = MODE_NORMAL;
  bit          mask_long = 1'b0;
  bit          mask_closed = 1'b0;

  greedy_wildcard_matcher_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] upcase(input logic [7:0] s);
    if (s >= LOWER_A && s <= LOWER_Z) begin
      return s - CASE_OFS;
    end
    return s;
  endfunction

  // Past the loaded bytes the mask reads as its terminator
  function automatic logic [7:0] mask_byte(input int unsigned p);
    if (p < held_len) begin
      return mask_copy[p];
    end
    return SYM_END;
  endfunction

  // Advance the model by one byte; returns 1 when a verdict comes out
  function automatic bit judge_symbol(input logic func, input logic [7:0] raw,
                                      output verdict_t v);
    logic [7:0] f;
    logic [7:0] m;
    bit done;
    bit hit;
    f = upcase(raw);
    v = '0;
    done = 1'b0;
    hit = 1'b0;
    if (func == FUNC_MASK) begin
      if (mask_closed) begin
        held_len = 0;
        mask_long = 1'b0;
        mask_closed = 1'b0;
      end
      if (f == SYM_END) begin
        mask_closed = 1'b1;
      end else if (held_len < MASK_DEPTH) begin
        mask_copy[held_len] = f;
        held_len++;
      end else begin
        mask_long = 1'b1;
      end
      cur_pos = 0;
      cur_mode = MODE_NORMAL;
      return 1'b0;
    end
    mask_closed = 1'b1;
    case (cur_mode)
      MODE_FAIL: begin
        done = (f == SYM_END);
      end
      MODE_SKIP: begin
        if (f == mask_byte(cur_pos)) begin
          if (f == SYM_END) begin
            done = 1'b1;
            hit = 1'b1;
          end else begin
            cur_pos++;
            cur_mode = MODE_NORMAL;
          end
        end else begin
          done = (f == SYM_END);
        end
      end
      default: begin
        m = mask_byte(cur_pos);
        if (f == SYM_END) begin
          done = 1'b1;
          hit = (m == SYM_END) || (m == SYM_STAR && mask_byte(cur_pos + 1) == SYM_END);
        end else if (m == SYM_ANY || m == f) begin
          cur_pos++;
        end else if (m == SYM_STAR) begin
          cur_pos++;
          if (f == mask_byte(cur_pos)) begin
            cur_pos++;
          end else begin
            cur_mode = MODE_SKIP;
          end
        end else begin
          cur_mode = MODE_FAIL;
        end
      end
    endcase
    if (done) begin
      v.matched = hit;
      v.too_long = mask_long;
      cur_pos = 0;
      cur_mode = MODE_NORMAL;
    end
    return done;
  endfunction

  // Random letter case on A..Z
  function automatic logic [7:0] any_case(input logic [7:0] s);
    if (s >= 8'h41 && s <= 8'h5A && $urandom_range(0, 1) == 1) begin
      return s + CASE_OFS;
    end
    return s;
  endfunction

  // Small alphabet so that names often match; now and then any nonzero byte
  function automatic logic [7:0] pick_symbol(input bit wild);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (wild && r < 2) begin
      return SYM_STAR;
    end else if (wild && r == 2) begin
      return SYM_ANY;
    end else if (r == 9) begin
      return 8'($urandom_range(1, 255));
    end
    return 8'h41 + 8'($urandom_range(0, 3));
  endfunction

  task automatic add_item(input logic func, input logic [7:0] sym);
    item_t it;
    it = '0;
    it.func = func;
    it.sym = sym;
    byte_stream.push_back(it);
  endtask

  // Masks followed by names built from them; some noise and broken names
  task automatic build_random_part;
    logic [7:0] pattern [$];
    int unsigned seq;
    int unsigned len;
    int unsigned names;
    seq = 0;
    while (byte_stream.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        // one run fills the whole store and runs past it
        len = (seq == 4) ? MASK_DEPTH + 3 : $urandom_range(0, 7);
        pattern.delete();
        repeat (len) pattern.push_back(pick_symbol(1'b1));
        foreach (pattern[i]) add_item(FUNC_MASK, any_case(pattern[i]));
        // sometimes the first name byte closes the mask instead
        if ($urandom_range(0, 7) != 0) begin
          add_item(FUNC_MASK, SYM_END);
        end
        names = (len > 16) ? 1 : $urandom_range(1, 5);
        repeat (names) begin
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(0, 6)) add_item(FUNC_NAME, 8'($urandom_range(1, 255)));
          end else begin
            foreach (pattern[i]) begin
              if (i < MASK_DEPTH) begin
                if (pattern[i] == SYM_ANY) begin
                  add_item(FUNC_NAME, 8'($urandom_range(1, 255)));
                end else if (pattern[i] == SYM_STAR) begin
                  repeat ($urandom_range(0, 3)) add_item(FUNC_NAME, any_case(pick_symbol(1'b0)));
                end else begin
                  add_item(FUNC_NAME, any_case(pattern[i]));
                end
                if ($urandom_range(0, 29) == 0) begin
                  add_item(FUNC_NAME, 8'($urandom_range(1, 255)));
                end
              end
            end
          end
          // a mask byte in the middle of a name rearms the matcher
          if ($urandom_range(0, 24) == 0) begin
            add_item(FUNC_MASK, pick_symbol(1'b1));
          end
          add_item(FUNC_NAME, SYM_END);
        end
        seq++;
      end
    end
  endtask

  // Scoreboard: results first, then the accepted input
  always @(posedge clk) begin
    verdict_t v;
    verdict_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with no name pending: m_tdata=%h", m_tdata);
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (m_tdata[0] !== want.matched) begin
            $error("matched: expected %0b, actual %0b", want.matched, m_tdata[0]);
            error_count++;
          end
          if (m_tdata[1] !== want.too_long) begin
            $error("mask_too_long: expected %0b, actual %0b", want.too_long, m_tdata[1]);
            error_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (judge_symbol(offered.func, offered.sym, v)) begin
          expected_verdicts.push_back(offered.typed ? offered.typed_v : v);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $error("no transaction for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: stall styles rotate on a loop counter; one long hold-off on request
  initial begin
    int unsigned rx_count;
    int unsigned style;
    rx_count = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        style = (rx_count / 64) % 4;
        case (style)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ((rx_count % 5) < 2);
          default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
      rx_count++;
    end
  end

  // Stimulus side
  initial begin
    int unsigned burst_left;
    int unsigned gap;
    foreach (DIRECTED[i]) byte_stream.push_back(DIRECTED[i]);
    build_random_part();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    burst_left = 0;
    for (int k = 0; k < byte_stream.size(); k++) begin
      if (k == DIRECTED_ROWS + 200) begin
        hold_req = 1'b1;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      offered = byte_stream[k];
      s_tvalid <= 1'b1;
      s_tdata <= byte_stream[k].sym;
      s_tuser <= byte_stream[k].func;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      @(negedge clk);
      burst_left--;
    end
    s_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/gwm_pkg.sv
hdl/gwm_ram.sv
hdl/gwm_core.sv
hdl/greedy_wildcard_matcher_unit.sv
test/greedy_wildcard_matcher_unit_test.sv
